// ===== hw/rtl/rfd_pkg.sv =====
// shared constants, types and state encodings of the reader frame deframer
package rfd_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 64;
  // head, type, command and both length bytes precede the payload
  localparam int unsigned HDR_LEN         = 5;
  localparam int unsigned FRAME_OVERHEAD  = 7;
  localparam int unsigned TAG_MIN_LEN     = 5;

  localparam logic [7:0] HEAD_BYTE   = 8'hAA;
  localparam logic [7:0] END_BYTE    = 8'hDD;
  localparam logic [7:0] TYPE_INFORM = 8'h02;
  localparam logic [7:0] CMD_READ    = 8'h22;
  localparam logic [7:0] CMD_MULTI   = 8'h27;

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_TYPE = 8'b0000_0010,
    PH_CMD  = 8'b0000_0100,
    PH_LENH = 8'b0000_1000,
    PH_LENL = 8'b0001_0000,
    PH_PAY  = 8'b0010_0000,
    PH_SUM  = 8'b0100_0000,
    PH_END  = 8'b1000_0000
  } parse_phase_e;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_READ     = 5'b00010,
    ST_PARSE    = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_OUT = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    logic wr_in;
    logic rd_byte;
    logic parse;
    logic emit_rd;
    logic emit_load;
  } rfd_cmd_t;

  typedef struct packed {
    logic pending;
    logic frame_good;
    logic emit_empty;
    logic emit_last;
    logic out_free;
  } rfd_sts_t;

endpackage

// ===== hw/rtl/rfd_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module rfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rfd_ctrl.sv =====
// sequencing state machine: byte fetch, parse step and result emission
module rfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rfd_pkg::rfd_sts_t sts_i,
  output rfd_pkg::rfd_cmd_t cmd_o
);

  rfd_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      rfd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.wr_in = 1'b1;
          state_d     = rfd_pkg::ST_READ;
        end
      end
      rfd_pkg::ST_READ: begin
        cmd_o.rd_byte = 1'b1;
        state_d       = rfd_pkg::ST_PARSE;
      end
      rfd_pkg::ST_PARSE: begin
        cmd_o.parse = 1'b1;
        if (sts_i.frame_good) begin
          state_d = sts_i.emit_empty ? rfd_pkg::ST_EMIT_OUT : rfd_pkg::ST_EMIT_RD;
        end else begin
          state_d = sts_i.pending ? rfd_pkg::ST_READ : rfd_pkg::ST_IDLE;
        end
      end
      rfd_pkg::ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = rfd_pkg::ST_EMIT_OUT;
      end
      rfd_pkg::ST_EMIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = sts_i.pending ? rfd_pkg::ST_READ : rfd_pkg::ST_IDLE;
          end else begin
            state_d = rfd_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_d = rfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != rfd_pkg::ST_IDLE);

endmodule

// ===== hw/rtl/rfd_datapath.sv =====
// byte buffer, frame field registers, parse step and output register
module rfd_datapath #(
  parameter int unsigned PAYLOAD_MAX = rfd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfd_pkg::rfd_cmd_t cmd_i,
  output rfd_pkg::rfd_sts_t sts_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        frame_type_o,
  output logic [7:0]        command_o,
  output logic              tag_report_o,
  output logic [6:0]        payload_length_o,
  output logic [5:0]        byte_index_o,
  output logic [7:0]        data_byte_o,
  output logic              has_data_o,
  output logic              last_o
);

  // the live region runs from the head to the write pointer, never past one frame
  localparam int unsigned AW    = $clog2(PAYLOAD_MAX + rfd_pkg::FRAME_OVERHEAD + 1);
  localparam int unsigned DEPTH = 2 ** AW;

  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d, hp_q, hp_d;
  rfd_pkg::parse_phase_e phase_q, phase_d;
  logic [7:0] type_q, type_d, cmd_q, cmd_d, lenh_q, lenh_d;
  logic [7:0] sum_q, sum_d, chk_q, chk_d;
  logic [6:0] len_q, len_d, pay_cnt_q, pay_cnt_d;
  logic [5:0] k_q, k_d;
  logic       frame_good;
  logic       tag;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic       out_valid_q;
  logic [7:0] out_type_q, out_cmd_q, out_data_q;
  logic       out_tag_q, out_has_q, out_last_q;
  logic [6:0] out_len_q;
  logic [5:0] out_idx_q;

  assign ram_re    = cmd_i.rd_byte | cmd_i.emit_rd;
  assign ram_raddr = cmd_i.emit_rd ? AW'(hp_q + AW'(rfd_pkg::HDR_LEN) + AW'(k_q)) : rp_q;

  rfd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_in),
    .waddr_i (wp_q),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // one parse step on the byte just read from the buffer
  always_comb begin
    rp_d       = rp_q;
    hp_d       = hp_q;
    phase_d    = phase_q;
    type_d     = type_q;
    cmd_d      = cmd_q;
    lenh_d     = lenh_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    len_d      = len_q;
    pay_cnt_d  = pay_cnt_q;
    frame_good = 1'b0;
    if (cmd_i.parse) begin
      rp_d = AW'(rp_q + AW'(1));
      unique case (phase_q)
        rfd_pkg::PH_HUNT: begin
          if (ram_rdata == rfd_pkg::HEAD_BYTE) begin
            hp_d    = rp_q;
            sum_d   = '0;
            phase_d = rfd_pkg::PH_TYPE;
          end
        end
        rfd_pkg::PH_TYPE: begin
          type_d  = ram_rdata;
          sum_d   = 8'(sum_q + ram_rdata);
          phase_d = rfd_pkg::PH_CMD;
        end
        rfd_pkg::PH_CMD: begin
          cmd_d   = ram_rdata;
          sum_d   = 8'(sum_q + ram_rdata);
          phase_d = rfd_pkg::PH_LENH;
        end
        rfd_pkg::PH_LENH: begin
          lenh_d  = ram_rdata;
          sum_d   = 8'(sum_q + ram_rdata);
          phase_d = rfd_pkg::PH_LENL;
        end
        rfd_pkg::PH_LENL: begin
          sum_d = 8'(sum_q + ram_rdata);
          if ((lenh_q != 8'd0) || (ram_rdata > 8'(PAYLOAD_MAX))) begin
            // oversized length: drop the head and rescan from the byte after it
            rp_d    = AW'(hp_q + AW'(1));
            phase_d = rfd_pkg::PH_HUNT;
          end else begin
            len_d     = 7'(ram_rdata);
            pay_cnt_d = '0;
            phase_d   = (ram_rdata != 8'd0) ? rfd_pkg::PH_PAY : rfd_pkg::PH_SUM;
          end
        end
        rfd_pkg::PH_PAY: begin
          sum_d     = 8'(sum_q + ram_rdata);
          pay_cnt_d = 7'(pay_cnt_q + 7'd1);
          if (7'(pay_cnt_q + 7'd1) == len_q) begin
            phase_d = rfd_pkg::PH_SUM;
          end
        end
        rfd_pkg::PH_SUM: begin
          chk_d   = ram_rdata;
          phase_d = rfd_pkg::PH_END;
        end
        rfd_pkg::PH_END: begin
          phase_d = rfd_pkg::PH_HUNT;
          if (ram_rdata != rfd_pkg::END_BYTE) begin
            // bad end byte: everything after the head goes through the hunt again
            rp_d = AW'(hp_q + AW'(1));
          end else if (chk_q == sum_q) begin
            frame_good = 1'b1;
          end
        end
        default: phase_d = rfd_pkg::PH_HUNT;
      endcase
    end
  end

  always_comb begin
    k_d = k_q;
    if (frame_good) begin
      k_d = '0;
    end else if (cmd_i.emit_load) begin
      k_d = 6'(k_q + 6'd1);
    end
  end

  assign wp_d = cmd_i.wr_in ? AW'(wp_q + AW'(1)) : wp_q;

  assign tag = (type_q == rfd_pkg::TYPE_INFORM) &&
               ((cmd_q == rfd_pkg::CMD_READ) || (cmd_q == rfd_pkg::CMD_MULTI)) &&
               (len_q >= 7'(rfd_pkg::TAG_MIN_LEN));

  assign sts_o.pending    = (rp_d != wp_q);
  assign sts_o.frame_good = frame_good;
  assign sts_o.emit_empty = (len_q == 7'd0);
  assign sts_o.emit_last  = (len_q == 7'd0) || (7'({1'b0, k_q} + 7'd1) == len_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rp_q        <= '0;
      hp_q        <= '0;
      phase_q     <= rfd_pkg::PH_HUNT;
      sum_q       <= '0;
      len_q       <= '0;
      pay_cnt_q   <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      hp_q        <= hp_d;
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      len_q       <= len_d;
      pay_cnt_q   <= pay_cnt_d;
      k_q         <= k_d;
      out_valid_q <= cmd_i.emit_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    cmd_q  <= cmd_d;
    lenh_q <= lenh_d;
    chk_q  <= chk_d;
    if (cmd_i.emit_load) begin
      out_type_q <= type_q;
      out_cmd_q  <= cmd_q;
      out_tag_q  <= tag;
      out_len_q  <= len_q;
      out_has_q  <= (len_q != 7'd0);
      out_idx_q  <= (len_q != 7'd0) ? k_q : 6'd0;
      out_data_q <= (len_q != 7'd0) ? ram_rdata : 8'd0;
      out_last_q <= sts_o.emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_type_o     = out_type_q;
  assign command_o        = out_cmd_q;
  assign tag_report_o     = out_tag_q;
  assign payload_length_o = out_len_q;
  assign byte_index_o     = out_idx_q;
  assign data_byte_o      = out_data_q;
  assign has_data_o       = out_has_q;
  assign last_o           = out_last_q;

endmodule

// ===== hw/rtl/reader_frame_deframer.sv =====
// top level of the reader frame deframer: controller, datapath and checks
// usage:
// - input channel: one received byte per transaction on rx_byte_i, in_valid_i and
//   in_stall_o; output channel: one payload byte of a good frame per transaction,
//   or a single has_data_o=0 result for a frame with no payload, last_o on the final one
// - frames are head 0xaa, type, command, 16-bit length, payload, additive checksum and
//   end byte 0xdd; bad checksums are dropped, a bad end byte or an oversized length
//   rescans the bytes after the head
// - every byte goes into a circular byte buffer; the parser reads it back one byte per
//   step through the buffer's single read port
// - each byte takes a write, a buffer read and a parse step before the next one is
//   accepted; a rescan repeats the buffer read and parse step for each byte read again
// - each result of a good frame takes a buffer read and an output load, an empty frame
//   only the output load, which waits while a stalled receiver holds the output register;
//   emission begins once the end byte's parse step finds the frame good
// - in_stall_o is high from the accepting edge until all work caused by the byte,
//   rescans and results included, has been done
// - a stalled receiver holds the output register and pauses emission; nothing is lost
// - reset returns the parser to hunting for a head with an empty buffer; no clearing
//   pass is needed, the buffer contents are never read before they are written
module reader_frame_deframer #(
  parameter int unsigned PAYLOAD_MAX = rfd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_type_o,
  output logic [7:0] command_o,
  output logic       tag_report_o,
  output logic [6:0] payload_length_o,
  output logic [5:0] byte_index_o,
  output logic [7:0] data_byte_o,
  output logic       has_data_o,
  output logic       last_o
);

  rfd_pkg::rfd_cmd_t cmd;
  rfd_pkg::rfd_sts_t sts;

  rfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfd_datapath #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .rx_byte_i        (rx_byte_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .frame_type_o     (frame_type_o),
    .command_o        (command_o),
    .tag_report_o     (tag_report_o),
    .payload_length_o (payload_length_o),
    .byte_index_o     (byte_index_o),
    .data_byte_o      (data_byte_o),
    .has_data_o       (has_data_o),
    .last_o           (last_o)
  );

  // an accepted byte always needs a read and a parse step before the next one
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_data_o) |-> (last_o && payload_length_o == 7'd0))
    else $error("empty-frame result malformed");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_data_o) |-> ({1'b0, byte_index_o} < payload_length_o))
    else $error("byte index beyond payload length");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_data_o && last_o) |->
      (7'({1'b0, byte_index_o} + 7'd1) == payload_length_o))
    else $error("last mark on wrong payload byte");

  a_tag_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tag_report_o) |-> (payload_length_o >= 7'(rfd_pkg::TAG_MIN_LEN)))
    else $error("tag report on short payload");

endmodule
